// ===== hdl/psrt_pkg.sv =====
package psrt_pkg;

  localparam int MAX_PARTS = 64;
  localparam int CNT_W     = 7;
  localparam int PART_W    = 6;
  localparam int EPP_W     = 24;
  localparam int EB_W      = 9;
  localparam int TAG_W     = 15;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_W     = 2;
  localparam int ERR_W     = 2;
  localparam int BASE_W    = 13;
  localparam int EC_W      = 30;
  localparam int OFF_W     = 48;
  localparam int OTAG_W    = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_READY = 2'd1,
    CMD_CTS   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_PARTS = 2'd0,
    REG_ELEM_PER  = 2'd1,
    REG_ELEM_SIZE = 2'd2,
    REG_BASE_TAG  = 2'd3
  } reg_idx_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_NOT_STARTED = 2'd1,
    ERR_DUP_READY   = 2'd2,
    ERR_RANGE       = 2'd3
  } err_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic start_round;
    logic ready_capture;
    logic cts_apply;
    logic div_go;
    logic div_sel_range;
    logic load_cts;
    logic load_range;
    logic scan_step;
    logic range_step;
    logic flush;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cts_seen;
    logic scan_more;
    logic range_empty;
    logic range_end;
    logic div_done;
    logic pipe_busy;
  } dp_stat_t;

endpackage

// ===== hdl/psrt_div.sv =====
module psrt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [psrt_pkg::CNT_W-1:0] dividend,
  input  logic [psrt_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [psrt_pkg::CNT_W-1:0] quotient,
  output logic [psrt_pkg::CNT_W-1:0] remainder
);
  import psrt_pkg::*;

  localparam int STEP_W = $clog2(CNT_W + 1);

  logic [CNT_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [CNT_W:0]    acc;
  logic [CNT_W:0]    diff;

  // One restoring step per cycle, most significant dividend bit first.
  assign acc  = {rem_r, quo_r[CNT_W-1]};
  assign diff = acc - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(CNT_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      if (!diff[CNT_W]) begin
        rem_r <= diff[CNT_W-1:0];
        quo_r <= {quo_r[CNT_W-2:0], 1'b1};
      end else begin
        rem_r <= acc[CNT_W-1:0];
        quo_r <= {quo_r[CNT_W-2:0], 1'b0};
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/psrt_ctrl.sv =====
module psrt_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [psrt_pkg::CMD_W-1:0] in_command,
  input  psrt_pkg::dp_stat_t         stat,
  output psrt_pkg::dp_cmd_t          cmd,
  output logic                       busy
);
  import psrt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_RANGE = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t st_r, st_nxt;
  logic   mode_range_r, mode_range_nxt;
  logic   accept;

  assign busy   = (st_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    st_nxt         = st_r;
    mode_range_nxt = mode_range_r;
    cmd            = '0;
    cmd.accept     = accept;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_START: begin
              cmd.start_round = 1'b1;
              st_nxt          = S_SCAN;
            end
            CMD_READY: begin
              cmd.ready_capture = 1'b1;
              if (stat.range_empty) begin
                st_nxt = S_DRAIN;
              end else begin
                cmd.div_go        = 1'b1;
                cmd.div_sel_range = 1'b1;
                mode_range_nxt    = 1'b1;
                st_nxt            = S_DIV;
              end
            end
            CMD_CTS: begin
              if (stat.cts_seen) begin
                st_nxt = S_DRAIN;
              end else begin
                cmd.cts_apply  = 1'b1;
                cmd.div_go     = 1'b1;
                mode_range_nxt = 1'b0;
                st_nxt         = S_DIV;
              end
            end
            default: st_nxt = S_DRAIN;
          endcase
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (mode_range_r) begin
            cmd.load_range = 1'b1;
            st_nxt         = S_RANGE;
          end else begin
            cmd.load_cts = 1'b1;
            st_nxt       = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_more) begin
          cmd.scan_step = 1'b1;
        end else begin
          st_nxt = S_DRAIN;
        end
      end
      S_RANGE: begin
        cmd.range_step = 1'b1;
        if (stat.range_end) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          st_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        st_nxt    = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      mode_range_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      mode_range_r <= mode_range_nxt;
    end
  end

  a_flush_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FLUSH |=> st_r == S_IDLE)
    else $error("flush did not return to idle");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> st_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && start && in_command == CMD_START) |=> st_r == S_SCAN)
    else $error("start command did not begin a scan");

endmodule

// ===== hdl/psrt_dp.sv =====
module psrt_dp #(
  parameter int MAX_PARTITIONS = psrt_pkg::MAX_PARTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psrt_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [psrt_pkg::PART_W-1:0]    in_first_partition,
  input  logic [psrt_pkg::PART_W-1:0]    in_last_partition,
  input  logic [psrt_pkg::CNT_W-1:0]     in_peer_groups,
  input  psrt_pkg::dp_cmd_t              cmd,
  output psrt_pkg::dp_stat_t             stat,
  output logic                           out_strobe,
  output logic                           out_issue_send,
  output logic [psrt_pkg::PART_W-1:0]    out_group_index,
  output logic [psrt_pkg::EC_W-1:0]      out_element_count,
  output logic [psrt_pkg::OFF_W-1:0]     out_byte_offset,
  output logic [psrt_pkg::OTAG_W-1:0]    out_message_tag,
  output logic [psrt_pkg::ERR_W-1:0]     out_error_code,
  output logic                           out_round_done,
  output logic                           out_last
);
  import psrt_pkg::*;

  localparam int HI_W  = BASE_W + 1;
  localparam int BE_W  = BASE_W + EPP_W;
  localparam int PEC_W = CNT_W + EPP_W;
  localparam int PR_W  = BE_W + EB_W;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > CNT_W'(MAX_PARTITIONS)) begin
      return CNT_W'(MAX_PARTITIONS);
    end else begin
      return v;
    end
  endfunction

  // Configuration and round state.
  logic [CNT_W-1:0]          np_r, np_nxt;
  logic [EPP_W-1:0]          epp_r, epp_nxt;
  logic [EB_W-1:0]           eb_r, eb_nxt;
  logic [TAG_W-1:0]          tag_r, tag_nxt;
  logic [MAX_PARTITIONS-1:0] bits_r, bits_nxt;
  logic                      started_r, started_nxt;
  logic                      cts_r, cts_nxt;
  logic [CNT_W-1:0]          gc_r, gc_nxt;
  logic [CNT_W-1:0]          gs_r, gs_nxt;
  logic [CNT_W-1:0]          sent_r, sent_nxt;
  logic [PART_W-1:0]         p_r, p_nxt;
  logic [PART_W-1:0]         last_r, last_nxt;
  logic [CNT_W-1:0]          g_r, g_nxt;
  logic [CNT_W-1:0]          r_r, r_nxt;
  logic [ERR_W-1:0]          err_r, err_nxt;

  // Walk logic.
  logic [CNT_W-1:0]          peer_c;
  logic [CNT_W-1:0]          gc_new;
  logic [CNT_W-1:0]          div_a;
  logic [CNT_W-1:0]          div_b;
  logic                      div_done;
  logic [CNT_W-1:0]          div_q;
  logic [CNT_W-1:0]          div_rem;
  logic [MAX_PARTITIONS-1:0] pmask;
  logic [MAX_PARTITIONS-1:0] bits_eff;
  logic [BASE_W-1:0]         base;
  logic [HI_W-1:0]           hi;
  logic                      grp_ok;
  logic [BASE_W-1:0]         np_b;
  logic [BASE_W-1:0]         pdiff;
  logic [CNT_W-1:0]          parts;
  logic                      r_not_started;
  logic                      r_oob;
  logic                      r_dup;
  logic                      rstep_ok;
  logic                      fire;
  logic [CNT_W-1:0]          sent_inc;
  logic                      round_end;

  // Issue pipeline.
  logic                      s1_v_r;
  logic [PART_W-1:0]         s1_g_r;
  logic [BASE_W-1:0]         s1_base_r;
  logic [CNT_W-1:0]          s1_parts_r;
  logic                      s1_done_r;
  logic                      s2_v_r;
  logic [PART_W-1:0]         s2_g_r;
  logic [BE_W-1:0]           s2_be_r;
  logic [PEC_W-1:0]          s2_ec_r;
  logic                      s2_done_r;
  logic [PR_W-1:0]           off_prod;
  logic                      pend_v_r;
  logic [PART_W-1:0]         pend_g_r;
  logic [EC_W-1:0]           pend_ec_r;
  logic [OFF_W-1:0]          pend_off_r;
  logic [OTAG_W-1:0]         pend_tag_r;
  logic                      pend_done_r;

  logic                      out_strobe_r;
  logic                      out_issue_r;
  logic [PART_W-1:0]         out_g_r;
  logic [EC_W-1:0]           out_ec_r;
  logic [OFF_W-1:0]          out_off_r;
  logic [OTAG_W-1:0]         out_tag_r;
  logic [ERR_W-1:0]          out_err_r;
  logic                      out_done_r;
  logic                      out_last_r;

  assign peer_c = clamp_count(in_peer_groups);
  assign gc_new = (peer_c < gc_r) ? peer_c : gc_r;
  assign div_a  = cmd.div_sel_range ? CNT_W'(in_first_partition)
                                    : CNT_W'({1'b0, np_r} + {1'b0, gc_new} - (CNT_W+1)'(1));
  assign div_b  = cmd.div_sel_range ? gs_r : gc_new;

  psrt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (cmd.div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign pmask    = MAX_PARTITIONS'(1) << p_r;
  assign bits_eff = cmd.range_step ? (bits_r | pmask) : bits_r;

  // A group is ready when every partition it covers below the count is marked.
  always_comb begin
    base   = BASE_W'(g_r[PART_W-1:0]) * BASE_W'(gs_r);
    hi     = HI_W'(base) + HI_W'(gs_r);
    grp_ok = 1'b1;
    for (int i = 0; i < MAX_PARTITIONS; i++) begin
      if (HI_W'(i) >= HI_W'(base) && HI_W'(i) < hi && CNT_W'(i) < np_r && !bits_eff[i]) begin
        grp_ok = 1'b0;
      end
    end
  end

  always_comb begin
    np_b  = BASE_W'(np_r);
    pdiff = np_b - base;
    if (np_b > base) begin
      parts = (pdiff > BASE_W'(gs_r)) ? gs_r : pdiff[CNT_W-1:0];
    end else begin
      parts = '0;
    end
  end

  assign r_not_started = !started_r;
  assign r_oob         = ({1'b0, p_r} >= np_r);
  assign r_dup         = |(bits_r & pmask);
  assign rstep_ok      = !r_not_started && !r_oob && !r_dup;

  assign fire = (cmd.scan_step && grp_ok) ||
                (cmd.range_step && rstep_ok && cts_r && (g_r < gc_r) && grp_ok);
  assign sent_inc  = sent_r + CNT_W'(1);
  assign round_end = fire && (sent_inc >= gc_r);

  always_comb begin
    np_nxt      = np_r;
    epp_nxt     = epp_r;
    eb_nxt      = eb_r;
    tag_nxt     = tag_r;
    bits_nxt    = bits_r;
    started_nxt = started_r;
    cts_nxt     = cts_r;
    gc_nxt      = gc_r;
    gs_nxt      = gs_r;
    sent_nxt    = sent_r;
    p_nxt       = p_r;
    last_nxt    = last_r;
    g_nxt       = g_r;
    r_nxt       = r_r;
    err_nxt     = err_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_PARTS: begin
          np_nxt = clamp_count(cfg_wdata[CNT_W-1:0]);
          gc_nxt = clamp_count(cfg_wdata[CNT_W-1:0]);
          gs_nxt = CNT_W'(1);
        end
        REG_ELEM_PER:  epp_nxt = cfg_wdata[EPP_W-1:0];
        REG_ELEM_SIZE: eb_nxt  = cfg_wdata[EB_W-1:0];
        REG_BASE_TAG:  tag_nxt = cfg_wdata[TAG_W-1:0];
        default: ;
      endcase
    end

    if (cmd.accept) begin
      err_nxt = ERR_OK;
    end
    if (cmd.start_round) begin
      bits_nxt    = '0;
      sent_nxt    = '0;
      started_nxt = 1'b1;
      g_nxt       = '0;
    end
    if (cmd.ready_capture) begin
      p_nxt    = in_first_partition;
      last_nxt = in_last_partition;
    end
    if (cmd.cts_apply) begin
      cts_nxt = 1'b1;
      gc_nxt  = gc_new;
    end
    if (cmd.load_cts) begin
      gs_nxt = div_q;
      g_nxt  = '0;
    end
    if (cmd.load_range) begin
      g_nxt = div_q;
      r_nxt = div_rem;
    end
    if (cmd.scan_step) begin
      g_nxt = g_r + CNT_W'(1);
    end
    if (cmd.range_step) begin
      if (r_not_started) begin
        err_nxt = ERR_NOT_STARTED;
      end else if (r_oob) begin
        err_nxt = ERR_RANGE;
      end else if (r_dup) begin
        err_nxt = ERR_DUP_READY;
      end else begin
        bits_nxt = bits_r | pmask;
      end
      p_nxt = p_r + PART_W'(1);
      if (r_r + CNT_W'(1) == gs_r) begin
        r_nxt = '0;
        g_nxt = g_r + CNT_W'(1);
      end else begin
        r_nxt = r_r + CNT_W'(1);
      end
    end
    if (fire) begin
      sent_nxt = sent_inc;
      if (round_end) begin
        started_nxt = 1'b0;
        cts_nxt     = 1'b0;
        sent_nxt    = '0;
        bits_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_r      <= CNT_W'(1);
      epp_r     <= EPP_W'(1);
      eb_r      <= EB_W'(1);
      tag_r     <= '0;
      bits_r    <= '0;
      started_r <= 1'b0;
      cts_r     <= 1'b0;
      gc_r      <= CNT_W'(1);
      gs_r      <= CNT_W'(1);
      sent_r    <= '0;
      p_r       <= '0;
      last_r    <= '0;
      g_r       <= '0;
      r_r       <= '0;
      err_r     <= ERR_OK;
    end else begin
      np_r      <= np_nxt;
      epp_r     <= epp_nxt;
      eb_r      <= eb_nxt;
      tag_r     <= tag_nxt;
      bits_r    <= bits_nxt;
      started_r <= started_nxt;
      cts_r     <= cts_nxt;
      gc_r      <= gc_nxt;
      gs_r      <= gs_nxt;
      sent_r    <= sent_nxt;
      p_r       <= p_nxt;
      last_r    <= last_nxt;
      g_r       <= g_nxt;
      r_r       <= r_nxt;
      err_r     <= err_nxt;
    end
  end

  assign off_prod = PR_W'(s2_be_r) * PR_W'(eb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_v_r       <= fire;
      s2_v_r       <= s1_v_r;
      out_strobe_r <= (s2_v_r && pend_v_r) || cmd.flush;
      if (s2_v_r) begin
        pend_v_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // The newest issued word waits in the pending stage, so that the final word
  // of a command can carry the last mark and the error code.
  always_ff @(posedge clk) begin
    s1_g_r     <= g_r[PART_W-1:0];
    s1_base_r  <= base;
    s1_parts_r <= parts;
    s1_done_r  <= round_end;
    s2_g_r     <= s1_g_r;
    s2_be_r    <= BE_W'(s1_base_r) * BE_W'(epp_r);
    s2_ec_r    <= PEC_W'(s1_parts_r) * PEC_W'(epp_r);
    s2_done_r  <= s1_done_r;
    if (s2_v_r) begin
      pend_g_r    <= s2_g_r;
      pend_ec_r   <= s2_ec_r[EC_W-1:0];
      pend_off_r  <= off_prod[OFF_W-1:0];
      pend_tag_r  <= OTAG_W'(tag_r) + OTAG_W'(s2_g_r) + OTAG_W'(1);
      pend_done_r <= s2_done_r;
    end
    if (s2_v_r && pend_v_r) begin
      out_issue_r <= 1'b1;
      out_g_r     <= pend_g_r;
      out_ec_r    <= pend_ec_r;
      out_off_r   <= pend_off_r;
      out_tag_r   <= pend_tag_r;
      out_err_r   <= ERR_OK;
      out_done_r  <= pend_done_r;
      out_last_r  <= 1'b0;
    end else if (cmd.flush) begin
      out_issue_r <= pend_v_r;
      out_g_r     <= pend_v_r ? pend_g_r : '0;
      out_ec_r    <= pend_v_r ? pend_ec_r : '0;
      out_off_r   <= pend_v_r ? pend_off_r : '0;
      out_tag_r   <= pend_v_r ? pend_tag_r : '0;
      out_err_r   <= err_r;
      out_done_r  <= pend_v_r && pend_done_r;
      out_last_r  <= 1'b1;
    end
  end

  assign stat.cts_seen    = cts_r;
  assign stat.scan_more   = (g_r < gc_r) && started_r && cts_r;
  assign stat.range_empty = (in_first_partition > in_last_partition);
  assign stat.range_end   = !rstep_ok || (p_r == last_r);
  assign stat.div_done    = div_done;
  assign stat.pipe_busy   = s1_v_r || s2_v_r;

  assign out_strobe        = out_strobe_r;
  assign out_issue_send    = out_issue_r;
  assign out_group_index   = out_g_r;
  assign out_element_count = out_ec_r;
  assign out_byte_offset   = out_off_r;
  assign out_message_tag   = out_tag_r;
  assign out_error_code    = out_err_r;
  assign out_round_done    = out_done_r;
  assign out_last          = out_last_r;

  a_done_is_issue: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_done_r |-> out_issue_r)
    else $error("round done on a word that issues no send");

  a_round_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    round_end |=> !started_r && !cts_r && sent_r == '0)
    else $error("round end did not clear the round state");

endmodule

// ===== hdl/partitioned_send_ready_tracker_core.sv =====
// Send-side ready tracker for partitioned messages.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
// registers are the partition count, elements per partition, element size in
// bytes and the base tag. Write them only while busy is low.
// Commands: a command word is taken at a clock edge where start is high and
// busy is low. Busy then stays high until the cycle in which the command's last
// result word is shown; one command is worked on at a time.
// Results: each result word is on the out_ ports for one cycle with out_strobe
// high. Every command yields one or more words, the final one marked by
// out_last and carrying out_error_code. The receiver cannot stall this port.
// Flow: a repeated clear-to-send, an empty range or an unknown command drains
// the pipeline and flushes its one word. A start command scans one group per
// cycle until no group is left. A clear-to-send first divides for the group
// size, one quotient bit per cycle, before its scan. A ready range first
// divides, then walks one partition per cycle up to the last partition or
// an error. Each issued send passes the s1, s2 and pending stages of a
// multiply pipeline.
// Reset clears all ready bits and flags, sets the partition and group counts
// to one and returns the block to idle.
module partitioned_send_ready_tracker_core #(
  parameter int MAX_PARTITIONS = psrt_pkg::MAX_PARTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psrt_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic [psrt_pkg::CMD_W-1:0]     in_command,
  input  logic [psrt_pkg::PART_W-1:0]    in_first_partition,
  input  logic [psrt_pkg::PART_W-1:0]    in_last_partition,
  input  logic [psrt_pkg::CNT_W-1:0]     in_peer_groups,
  output logic                           out_strobe,
  output logic                           out_issue_send,
  output logic [psrt_pkg::PART_W-1:0]    out_group_index,
  output logic [psrt_pkg::EC_W-1:0]      out_element_count,
  output logic [psrt_pkg::OFF_W-1:0]     out_byte_offset,
  output logic [psrt_pkg::OTAG_W-1:0]    out_message_tag,
  output logic [psrt_pkg::ERR_W-1:0]     out_error_code,
  output logic                           out_round_done,
  output logic                           out_last
);
  import psrt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  psrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  psrt_dp #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_first_partition (in_first_partition),
    .in_last_partition  (in_last_partition),
    .in_peer_groups     (in_peer_groups),
    .cmd                (cmd),
    .stat               (stat),
    .out_strobe         (out_strobe),
    .out_issue_send     (out_issue_send),
    .out_group_index    (out_group_index),
    .out_element_count  (out_element_count),
    .out_byte_offset    (out_byte_offset),
    .out_message_tag    (out_message_tag),
    .out_error_code     (out_error_code),
    .out_round_done     (out_round_done),
    .out_last           (out_last)
  );

endmodule
